[rtl/padsr_pkg.sv]
`timescale 1ns / 1ps
package padsr_pkg;
    localparam int MaxVoices = 16;
    localparam int LevelFracBits = 23;
    localparam int IdBits = 16;
    localparam int RegBits = 24;
    localparam int QueueDepth = 2;

    typedef enum logic [1:0] {
        FUNC_NOTE_ON  = 2'd0,
        FUNC_NOTE_OFF = 2'd1,
        FUNC_OTHER    = 2'd2,
        FUNC_TICK     = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CFG_ATTACK  = 2'd0,
        CFG_DECAY   = 2'd1,
        CFG_SUSTAIN = 2'd2,
        CFG_RELEASE = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_ATTACK  = 2'd0,
        ST_DECAY   = 2'd1,
        ST_SUSTAIN = 2'd2,
        ST_RELEASE = 2'd3
    } t_stage;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] note_id;
        logic [7:0]  event_code;
        logic [31:0] event_value;
    } t_word;
endpackage

[rtl/padsr_front.sv]
`timescale 1ns / 1ps
module padsr_front
    import padsr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_word       i_word,
    output logic        o_valid,
    input  logic        i_stall,
    output t_word       o_word
);
    localparam int PtrBits = $clog2(QueueDepth);

    t_word                r_mem [QueueDepth];
    logic [PtrBits-1:0]   r_wp, r_rp;
    logic [PtrBits:0]     r_cnt;
    logic                 push, pop;

    assign o_stall = (r_cnt == (PtrBits+1)'(QueueDepth));
    assign o_valid = (r_cnt != '0);
    assign o_word  = r_mem[r_rp];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
        end
        if (push) r_mem[r_wp] <= i_word;
    end
endmodule

[rtl/padsr_back.sv]
`timescale 1ns / 1ps
module padsr_back
    import padsr_pkg::*;
#(
    parameter int MAX_VOICES = MaxVoices,
    parameter int LEVEL_FRAC_BITS = LevelFracBits,
    parameter int ID_BITS = IdBits
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [RegBits-1:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_word       i_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_out_kind,
    output logic [1:0]  o_event_kind,
    output logic [7:0]  o_event_code_out,
    output logic [15:0] o_note_id_out,
    output logic [31:0] o_event_value_out,
    output logic [23:0] o_sample_level,
    output logic        o_table_full,
    output logic        o_last
);
    localparam int VB = $clog2(MAX_VOICES);
    localparam int CB = VB + 1;
    localparam int LB = LEVEL_FRAC_BITS + 2;
    localparam int SB = LB + CB;
    localparam logic [LB-1:0] One = LB'(1) << LEVEL_FRAC_BITS;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FIND  = 7'b0000010,
        S_SHIFT = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_TICK  = 7'b0010000,
        S_PACK  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state r_state;
    t_word  r_w;
    logic [RegBits-1:0] r_att, r_dec, r_sus, r_rel;
    logic [ID_BITS-1:0] r_id [MAX_VOICES];
    t_stage             r_stg [MAX_VOICES];
    logic [LB-1:0]      r_lvl [MAX_VOICES];
    logic [LB-1:0]      r_rstep [MAX_VOICES];
    logic [MAX_VOICES-1:0] r_gone;
    logic [CB-1:0] r_cnt, r_i, r_wr, r_pos;
    logic          r_found;
    logic [SB-1:0] r_sum;
    logic [LB+RegBits-1:0] r_prod;
    logic          r_ovalid, r_tick_fin;
    logic [ID_BITS-1:0] id_in;
    logic [VB-1:0] ix, ixm1, wx, px;
    logic [LB-1:0] sus, lv, att_lv, dec_lim, nstep;
    logic          ld_out;

    assign id_in = ID_BITS'(i_word.note_id);
    assign ix    = r_i[VB-1:0];
    assign ixm1  = VB'(r_i - 1'b1);
    assign wx    = r_wr[VB-1:0];
    assign px    = r_pos[VB-1:0];
    assign sus   = (LB'(r_sus) > One) ? One : LB'(r_sus);
    assign lv    = r_lvl[ix];
    assign att_lv  = lv + LB'(r_att);
    assign dec_lim = sus + LB'(r_dec);
    assign nstep = (r_prod >> LEVEL_FRAC_BITS) == '0 ? LB'(1)
                 : LB'(r_prod >> LEVEL_FRAC_BITS);
    assign o_stall = (r_state != S_IDLE) || (r_ovalid && i_stall);
    assign o_valid = r_ovalid;
    assign ld_out = ((r_state == S_IDLE) && i_valid && !o_stall
                     && (t_func'(i_word.func) == FUNC_OTHER))
                 || ((r_state == S_TICK) && !(r_ovalid && i_stall)
                     && ((r_i == r_cnt)
                         || ((r_stg[ix] == ST_RELEASE) && (lv <= r_rstep[ix]))));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_att <= RegBits'(1) << 23;
            r_dec <= RegBits'(1) << 23;
            r_sus <= RegBits'(1) << 23;
            r_rel <= RegBits'(1) << 23;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_ATTACK:  r_att <= i_cfg_data;
                    CFG_DECAY:   r_dec <= i_cfg_data;
                    CFG_SUSTAIN: r_sus <= i_cfg_data;
                    CFG_RELEASE: r_rel <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ovalid && !i_stall && !ld_out) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_w <= i_word;
                        r_i <= '0;
                        r_found <= 1'b0;
                        r_pos <= r_cnt;
                        if (t_func'(i_word.func) == FUNC_TICK) begin
                            r_sum <= '0;
                            r_wr <= '0;
                            r_gone <= '0;
                            r_state <= S_TICK;
                        end else if (t_func'(i_word.func) == FUNC_OTHER) begin
                            r_ovalid <= 1'b1;
                            o_out_kind <= 1'b0;
                            o_event_kind <= 2'd2;
                            o_event_code_out <= i_word.event_code;
                            o_note_id_out <= 16'(id_in);
                            o_event_value_out <= i_word.event_value;
                            o_sample_level <= '0;
                            o_table_full <= 1'b0;
                            o_last <= 1'b1;
                        end else begin
                            r_state <= S_FIND;
                        end
                    end
                end
                S_FIND: begin
                    if (r_i == r_cnt) begin
                        if (t_func'(r_w.func) == FUNC_NOTE_OFF) begin
                            r_ovalid <= 1'b1;
                            o_out_kind <= 1'b0;
                            o_event_kind <= 2'd1;
                            o_event_code_out <= '0;
                            o_note_id_out <= 16'(ID_BITS'(r_w.note_id));
                            o_event_value_out <= r_w.event_value;
                            o_sample_level <= '0;
                            o_table_full <= 1'b0;
                            o_last <= 1'b1;
                            r_state <= S_EMIT;
                        end else if (r_cnt == CB'(MAX_VOICES)) begin
                            r_ovalid <= 1'b1;
                            o_out_kind <= 1'b0;
                            o_event_kind <= 2'd0;
                            o_event_code_out <= '0;
                            o_note_id_out <= 16'(ID_BITS'(r_w.note_id));
                            o_event_value_out <= r_w.event_value;
                            o_sample_level <= '0;
                            o_table_full <= 1'b1;
                            o_last <= 1'b1;
                            r_state <= S_EMIT;
                        end else begin
                            r_i <= r_cnt;
                            r_cnt <= r_cnt + 1'b1;
                            r_state <= S_SHIFT;
                        end
                    end else if (r_id[ix] == ID_BITS'(r_w.note_id)) begin
                        r_pos <= r_i;
                        if (t_func'(r_w.func) == FUNC_NOTE_OFF) begin
                            r_prod <= (LB+RegBits)'(lv) * (LB+RegBits)'(r_rel);
                            r_state <= S_MUL;
                        end else begin
                            r_i <= r_i;
                            r_found <= 1'b1;
                            r_state <= S_SHIFT;
                        end
                    end else begin
                        if (r_id[ix] > ID_BITS'(r_w.note_id) && r_pos == r_cnt)
                            r_pos <= r_i;
                        r_i <= r_i + 1'b1;
                    end
                end
                S_SHIFT: begin
                    if (r_found || r_i == r_pos) begin
                        r_id[px] <= ID_BITS'(r_w.note_id);
                        r_stg[px] <= ST_ATTACK;
                        r_lvl[px] <= '0;
                        r_rstep[px] <= '0;
                        r_ovalid <= 1'b1;
                        o_out_kind <= 1'b0;
                        o_event_kind <= 2'd0;
                        o_event_code_out <= '0;
                        o_note_id_out <= 16'(ID_BITS'(r_w.note_id));
                        o_event_value_out <= r_w.event_value;
                        o_sample_level <= '0;
                        o_table_full <= 1'b0;
                        o_last <= 1'b1;
                        r_state <= S_EMIT;
                    end else begin
                        r_id[ix] <= r_id[ixm1];
                        r_stg[ix] <= r_stg[ixm1];
                        r_lvl[ix] <= r_lvl[ixm1];
                        r_rstep[ix] <= r_rstep[ixm1];
                        r_i <= r_i - 1'b1;
                    end
                end
                S_MUL: begin
                    r_stg[px] <= ST_RELEASE;
                    r_rstep[px] <= nstep;
                    r_state <= S_IDLE;
                end
                S_TICK: begin
                    if (!(r_ovalid && i_stall)) begin
                        if (r_i == r_cnt) begin
                            r_ovalid <= 1'b1;
                            o_out_kind <= 1'b1;
                            o_event_kind <= '0;
                            o_event_code_out <= '0;
                            o_note_id_out <= '0;
                            o_event_value_out <= '0;
                            o_sample_level <= (r_sum > SB'(One)) ? 24'(One) : 24'(r_sum);
                            o_table_full <= 1'b0;
                            o_last <= 1'b1;
                            r_i <= '0;
                            r_state <= S_PACK;
                        end else begin
                            r_i <= r_i + 1'b1;
                            unique case (r_stg[ix])
                                ST_ATTACK: begin
                                    if (att_lv >= One) begin
                                        r_lvl[ix] <= One;
                                        r_stg[ix] <= ST_DECAY;
                                        r_sum <= r_sum + SB'(One);
                                    end else begin
                                        r_lvl[ix] <= att_lv;
                                        r_sum <= r_sum + SB'(att_lv);
                                    end
                                end
                                ST_DECAY: begin
                                    if (lv <= dec_lim) begin
                                        r_lvl[ix] <= sus;
                                        r_stg[ix] <= ST_SUSTAIN;
                                        r_sum <= r_sum + SB'(sus);
                                    end else begin
                                        r_lvl[ix] <= lv - LB'(r_dec);
                                        r_sum <= r_sum + SB'(lv - LB'(r_dec));
                                    end
                                end
                                ST_SUSTAIN: begin
                                    r_lvl[ix] <= sus;
                                    r_sum <= r_sum + SB'(sus);
                                end
                                ST_RELEASE: begin
                                    if (lv <= r_rstep[ix]) begin
                                        r_lvl[ix] <= '0;
                                        r_gone[ix] <= 1'b1;
                                        r_ovalid <= 1'b1;
                                        o_out_kind <= 1'b0;
                                        o_event_kind <= 2'd1;
                                        o_event_code_out <= '0;
                                        o_note_id_out <= 16'(r_id[ix]);
                                        o_event_value_out <= '0;
                                        o_sample_level <= '0;
                                        o_table_full <= 1'b0;
                                        o_last <= 1'b0;
                                    end else begin
                                        r_lvl[ix] <= lv - r_rstep[ix];
                                        r_sum <= r_sum + SB'(lv - r_rstep[ix]);
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                S_PACK: begin
                    if (r_i == r_cnt) begin
                        r_cnt <= r_wr;
                        r_state <= S_EMIT;
                    end else begin
                        if (!r_gone[ix]) begin
                            r_id[wx] <= r_id[ix];
                            r_stg[wx] <= r_stg[ix];
                            r_lvl[wx] <= r_lvl[ix];
                            r_rstep[wx] <= r_rstep[ix];
                            r_wr <= r_wr + 1'b1;
                        end
                        r_i <= r_i + 1'b1;
                    end
                end
                S_EMIT: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/polyphonic_adsr_envelope_top.sv]
`timescale 1ns / 1ps
// Polyphonic linear ADSR envelope generator. Words enter a two-entry queue,
// then a sequencer walks the voice table one slot per cycle, pausing in a
// tick pass while a result waits at a stalled output. A tick runs an advance
// pass, then compaction; a note-on with a new id runs a search, then a shift
// to insert; any other note event runs a search; an other event goes straight
// to the output register. A waiting result also holds off new words.
module polyphonic_adsr_envelope_top
    import padsr_pkg::*;
#(
    parameter int MAX_VOICES = MaxVoices,
    parameter int LEVEL_FRAC_BITS = LevelFracBits,
    parameter int ID_BITS = IdBits
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_note_id,
    input  logic [7:0]  i_event_code,
    input  logic [31:0] i_event_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_out_kind,
    output logic [1:0]  o_event_kind,
    output logic [7:0]  o_event_code_out,
    output logic [15:0] o_note_id_out,
    output logic [31:0] o_event_value_out,
    output logic [23:0] o_sample_level,
    output logic        o_table_full,
    output logic        o_last
);
    t_word in_w, q_w;
    logic  q_valid, q_stall;

    assign in_w = '{func: i_func, note_id: i_note_id, event_code: i_event_code,
                    event_value: i_event_value};

    padsr_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_word(in_w),
        .o_valid(q_valid), .i_stall(q_stall), .o_word(q_w)
    );

    padsr_back #(
        .MAX_VOICES(MAX_VOICES), .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS), .ID_BITS(ID_BITS)
    ) u_back (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid(q_valid), .o_stall(q_stall), .i_word(q_w),
        .o_valid, .i_stall, .o_out_kind, .o_event_kind, .o_event_code_out,
        .o_note_id_out, .o_event_value_out, .o_sample_level, .o_table_full, .o_last
    );
endmodule

[rtl/padsr_checker.sv]
`timescale 1ns / 1ps
module padsr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_out_kind,
    input logic [23:0] o_sample_level,
    input logic        o_table_full,
    input logic        o_last,
    input logic [31:0] o_event_value_out
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("dropped word");
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_sample_level <= 24'h800000) else $error("level over one");
    a_smp_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_kind |-> o_last && !o_table_full) else $error("bad sample");
    a_gen_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_event_value_out == 32'd0) else $error("bad note-off");
endmodule

bind polyphonic_adsr_envelope_top padsr_checker u_chk (.*);

[sim/envelope_checker.sv]
`timescale 1ns / 1ps
module envelope_checker
    import padsr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_note_id,
    input  logic [7:0]  i_event_code,
    input  logic [31:0] i_event_value,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_out_kind,
    input  logic [1:0]  i_event_kind,
    input  logic [7:0]  i_event_code_out,
    input  logic [15:0] i_note_id_out,
    input  logic [31:0] i_event_value_out,
    input  logic [23:0] i_sample_level,
    input  logic        i_table_full,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);
    localparam logic [24:0] OneLevel = 25'd1 << LevelFracBits;

    typedef struct packed {
        logic        out_kind;
        logic [1:0]  event_kind;
        logic [7:0]  event_code;
        logic [15:0] note_id;
        logic [31:0] event_value;
        logic [23:0] sample_level;
        logic        table_full;
        logic        last;
    } t_result;

    t_result expected_results[$];

    logic [23:0] attack_inc, decay_dec, sustain_lvl, release_recip;
    logic [15:0] v_id [MaxVoices];
    t_stage      v_stage [MaxVoices];
    logic [24:0] v_level [MaxVoices];
    logic [24:0] v_step [MaxVoices];
    int          v_count;
    int          fail_total = 0;

    function automatic t_result make_event(logic [1:0] ek, logic [7:0] code,
                                           logic [15:0] id, logic [31:0] val,
                                           logic full, logic lst);
        t_result r;
        r = '0;
        r.event_kind = ek;
        r.event_code = code;
        r.note_id = id;
        r.event_value = val;
        r.table_full = full;
        r.last = lst;
        return r;
    endfunction

    function automatic void add_expected(t_result r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    task automatic predict_envelope(logic [1:0] func, logic [15:0] id,
                                    logic [7:0] code, logic [31:0] val);
        int slot;
        int pos;
        int w;
        logic [47:0] prod;
        logic [24:0] sus;
        logic [24:0] lv;
        logic [29:0] sum;
        t_result r;
        bit gone [MaxVoices];
        slot = -1;
        for (int i = 0; i < v_count; i++)
            if (v_id[i] == id && slot < 0) slot = i;
        case (t_func'(func))
            FUNC_NOTE_ON: begin
                if (slot < 0 && v_count < MaxVoices) begin
                    pos = 0;
                    while (pos < v_count && v_id[pos] < id) pos++;
                    for (int i = v_count; i > pos; i--) begin
                        v_id[i] = v_id[i-1];
                        v_stage[i] = v_stage[i-1];
                        v_level[i] = v_level[i-1];
                        v_step[i] = v_step[i-1];
                    end
                    v_count++;
                    slot = pos;
                end
                if (slot < 0) begin
                    add_expected(make_event(2'd0, 8'd0, id, val, 1'b1, 1'b1));
                end else begin
                    v_id[slot] = id;
                    v_stage[slot] = ST_ATTACK;
                    v_level[slot] = '0;
                    v_step[slot] = '0;
                    add_expected(make_event(2'd0, 8'd0, id, val, 1'b0, 1'b1));
                end
            end
            FUNC_NOTE_OFF: begin
                if (slot < 0) begin
                    add_expected(make_event(2'd1, 8'd0, id, val, 1'b0, 1'b1));
                end else begin
                    prod = v_level[slot] * release_recip;
                    v_step[slot] = 25'(prod >> LevelFracBits);
                    if (v_step[slot] == 0) v_step[slot] = 25'd1;
                    v_stage[slot] = ST_RELEASE;
                end
            end
            FUNC_OTHER: begin
                add_expected(make_event(2'd2, code, id, val, 1'b0, 1'b1));
            end
            default: begin
                sus = (sustain_lvl > OneLevel) ? OneLevel : 25'(sustain_lvl);
                sum = '0;
                for (int i = 0; i < v_count; i++) begin
                    lv = v_level[i];
                    gone[i] = 1'b0;
                    case (v_stage[i])
                        ST_ATTACK: begin
                            lv = lv + attack_inc;
                            if (lv >= OneLevel) begin
                                lv = OneLevel;
                                v_stage[i] = ST_DECAY;
                            end
                        end
                        ST_DECAY: begin
                            if (26'(lv) <= 26'(sus) + decay_dec) begin
                                lv = sus;
                                v_stage[i] = ST_SUSTAIN;
                            end else begin
                                lv = lv - decay_dec;
                            end
                        end
                        ST_SUSTAIN: lv = sus;
                        default: begin
                            if (lv <= v_step[i]) begin
                                lv = '0;
                                gone[i] = 1'b1;
                                add_expected(
                                    make_event(2'd1, 8'd0, v_id[i], 32'd0, 1'b0, 1'b0));
                            end else begin
                                lv = lv - v_step[i];
                            end
                        end
                    endcase
                    v_level[i] = lv;
                    sum = sum + lv;
                end
                w = 0;
                for (int i = 0; i < v_count; i++) begin
                    if (!gone[i]) begin
                        v_id[w] = v_id[i];
                        v_stage[w] = v_stage[i];
                        v_level[w] = v_level[i];
                        v_step[w] = v_step[i];
                        w++;
                    end
                end
                v_count = w;
                r = '0;
                r.out_kind = 1'b1;
                r.sample_level = (sum > OneLevel) ? 24'(OneLevel) : 24'(sum);
                r.last = 1'b1;
                add_expected(r);
            end
        endcase
    endtask

    task automatic compare_result();
        t_result e;
        if (expected_results.size() == 0) begin
            $error("unexpected result word");
            fail_total++;
            return;
        end
        e = expected_results.pop_front();
        if (i_out_kind !== e.out_kind) begin
            $error("out_kind exp %0d got %0d", e.out_kind, i_out_kind);
            fail_total++;
        end
        if (i_event_kind !== e.event_kind) begin
            $error("event_kind exp %0d got %0d", e.event_kind, i_event_kind);
            fail_total++;
        end
        if (i_event_code_out !== e.event_code) begin
            $error("event_code_out exp %0d got %0d", e.event_code, i_event_code_out);
            fail_total++;
        end
        if (i_note_id_out !== e.note_id) begin
            $error("note_id_out exp %0d got %0d", e.note_id, i_note_id_out);
            fail_total++;
        end
        if (i_event_value_out !== e.event_value) begin
            $error("event_value_out exp %0h got %0h", e.event_value, i_event_value_out);
            fail_total++;
        end
        if (i_sample_level !== e.sample_level) begin
            $error("sample_level exp %0d got %0d", e.sample_level, i_sample_level);
            fail_total++;
        end
        if (i_table_full !== e.table_full) begin
            $error("table_full exp %0d got %0d", e.table_full, i_table_full);
            fail_total++;
        end
        if (i_last !== e.last) begin
            $error("last exp %0d got %0d", e.last, i_last);
            fail_total++;
        end
    endtask

    assign o_fail_count = fail_total;
    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            attack_inc <= 24'd8388608;
            decay_dec <= 24'd8388608;
            sustain_lvl <= 24'd8388608;
            release_recip <= 24'd8388608;
            v_count = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ATTACK:  attack_inc <= i_cfg_data;
                    CFG_DECAY:   decay_dec <= i_cfg_data;
                    CFG_SUSTAIN: sustain_lvl <= i_cfg_data;
                    default:     release_recip <= i_cfg_data;
                endcase
            end
            if (i_out_valid && !i_out_stall) compare_result();
            if (i_valid && !i_in_stall)
                predict_envelope(i_func, i_note_id, i_event_code, i_event_value);
        end
    end
endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
module testbench;
    import padsr_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = '0;
    logic [23:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  func = '0;
    logic [15:0] note_id = '0;
    logic [7:0]  event_code = '0;
    logic [31:0] event_value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        out_kind, table_full, last;
    logic [1:0]  event_kind;
    logic [7:0]  event_code_out;
    logic [15:0] note_id_out;
    logic [31:0] event_value_out;
    logic [23:0] sample_level;
    int          fail_count;
    int          pending;
    bit          hold_off = 1'b0;
    int          gap_left = 0;
    logic [15:0] held_ids [$];

    always #5 clk = ~clk;

    polyphonic_adsr_envelope_top u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_func(func), .i_note_id(note_id), .i_event_code(event_code),
        .i_event_value(event_value),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_out_kind(out_kind), .o_event_kind(event_kind),
        .o_event_code_out(event_code_out), .o_note_id_out(note_id_out),
        .o_event_value_out(event_value_out), .o_sample_level(sample_level),
        .o_table_full(table_full), .o_last(last)
    );

    envelope_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .i_in_stall(in_stall),
        .i_func(func), .i_note_id(note_id), .i_event_code(event_code),
        .i_event_value(event_value),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_out_kind(out_kind), .i_event_kind(event_kind),
        .i_event_code_out(event_code_out), .i_note_id_out(note_id_out),
        .i_event_value_out(event_value_out), .i_sample_level(sample_level),
        .i_table_full(table_full), .i_last(last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // stall on a shifting pattern, or hold off entirely when asked
    always @(negedge clk) begin
        if (hold_off) out_stall <= 1'b1;
        else begin
            case ((($time / 4000) % 3))
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    task automatic send_word(logic [1:0] f, logic [15:0] id, logic [7:0] code,
                             logic [31:0] val);
        if (gap_left == 0) begin
            if ($urandom_range(0, 2) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            gap_left = $urandom_range(1, 12);
        end
        gap_left--;
        in_valid <= 1'b1;
        func <= f;
        note_id <= id;
        event_code <= code;
        event_value <= val;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [23:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        int n;
        n = 0;
        in_valid <= 1'b0;
        while (pending != 0 && n < 200000) begin
            @(negedge clk);
            n++;
        end
        repeat (200) @(negedge clk);
    endtask

    task automatic random_note_word();
        int pick;
        logic [15:0] id;
        pick = $urandom_range(0, 99);
        if (pick < 30 || held_ids.size() == 0) begin
            id = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
            held_ids.insert(held_ids.size(), id);
            send_word(FUNC_NOTE_ON, id, 8'($urandom), $urandom);
        end else if (pick < 50) begin
            id = held_ids[$urandom_range(0, held_ids.size() - 1)];
            send_word(FUNC_NOTE_OFF, id, 8'($urandom), $urandom);
        end else if (pick < 58) begin
            send_word(FUNC_NOTE_OFF, 16'($urandom), 8'($urandom), $urandom);
        end else if (pick < 66) begin
            send_word(FUNC_OTHER, 16'($urandom), 8'($urandom), $urandom);
        end else begin
            send_word(FUNC_TICK, 16'($urandom), 8'($urandom), $urandom);
        end
        if (held_ids.size() > 40) held_ids.delete(0);
    endtask

    initial begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: fast envelopes, full table, restart, unknown off, passthrough
        send_word(FUNC_TICK, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        send_word(FUNC_OTHER, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        send_word(FUNC_OTHER, 16'h0000, 8'h00, 32'h0000_0000);
        send_word(FUNC_NOTE_OFF, 16'hFFFF, 8'h5A, 32'hA5A5_A5A5);
        for (int i = 0; i < 17; i++)
            send_word(FUNC_NOTE_ON, 16'(i * 4001), 8'h00, 32'(i));
        send_word(FUNC_NOTE_ON, 16'd4001, 8'h00, 32'h1234_5678);
        send_word(FUNC_TICK, 16'd0, 8'd0, 32'd0);
        send_word(FUNC_NOTE_OFF, 16'd0, 8'd0, 32'd0);
        send_word(FUNC_NOTE_OFF, 16'd0, 8'd0, 32'd0);
        send_word(FUNC_TICK, 16'd0, 8'd0, 32'd0);
        drain();

        // zero increments and zero release reciprocal, sustain above one
        write_reg(CFG_ATTACK, 24'd0);
        write_reg(CFG_DECAY, 24'd0);
        write_reg(CFG_SUSTAIN, 24'hFFFFFF);
        write_reg(CFG_RELEASE, 24'd0);
        for (int i = 0; i < 3; i++) send_word(FUNC_TICK, 16'd0, 8'd0, 32'd0);
        drain();

        write_reg(CFG_ATTACK, 24'd1 << 21);
        write_reg(CFG_DECAY, 24'd1 << 20);
        write_reg(CFG_SUSTAIN, 24'd1 << 22);
        write_reg(CFG_RELEASE, 24'd1 << 21);
        for (int i = 0; i < 60; i++) random_note_word();
        drain();

        write_reg(CFG_ATTACK, 24'hFFFFFF);
        write_reg(CFG_DECAY, 24'd1);
        write_reg(CFG_SUSTAIN, 24'd0);
        write_reg(CFG_RELEASE, 24'hFFFFFF);
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 40; i++) random_note_word();
        join
        drain();

        write_reg(CFG_ATTACK, 24'($urandom_range(1, 8388608)));
        write_reg(CFG_DECAY, 24'($urandom_range(0, 8388608)));
        write_reg(CFG_SUSTAIN, 24'($urandom_range(0, 8388608)));
        write_reg(CFG_RELEASE, 24'($urandom_range(1, 8388608)));
        for (int i = 0; i < 35; i++) random_note_word();
        drain();

        if (fail_count == 0 && pending == 0) $display("testbench OK");
        else $display("testbench NOT OK");
        $finish;
    end

    initial begin
        #20ms;
        $display("testbench NOT OK");
        $finish;
    end
endmodule
